// ===== hw/rtl/qtr_pkg.sv =====
// Shared constants and the result record for the three-point parabola root finder.
`timescale 1ns / 1ps
`default_nettype none

package qtr_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int OUT_W            = 32;
    localparam int Q_FRAC           = 24;
    localparam int RES_W            = 4 * OUT_W + 4;
    localparam int OUT_TDATA_W      = ((RES_W + 7) / 8) * 8;

    localparam logic signed [OUT_W-1:0] ONE_Q     = OUT_W'(1) <<< Q_FRAC;
    localparam logic signed [OUT_W-1:0] NEG_ONE_Q = -ONE_Q;
    localparam logic [OUT_W-1:0]        POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]        NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic              degenerate;
        logic              roots_real;
        logic [1:0]        root_count;
        logic signed [OUT_W-1:0] root_high;
        logic signed [OUT_W-1:0] root_low;
        logic signed [OUT_W-1:0] extremum_y;
        logic signed [OUT_W-1:0] extremum_x;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/quadratic_three_point_roots_core.sv =====
// Throughput: one sample triple per cycle unless the output buffer is full.
// The square root (SAMPLE_WIDTH + 26 stages) and the 33-stage divider lanes each retire
// one bit per stage and are fully pipelined.
// A two-entry output buffer keeps taking requests while one result waits.
// Reset is synchronous and active low; it clears all valid bits, data registers keep contents.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_three_point_roots_core
    import qtr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // y_minus, y_zero, y_plus (SAMPLE_WIDTH each), zero pad to bytes
    input  wire logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // extremum_x, extremum_y, root_low, root_high (32 each), root_count (2),
    // roots_real (1), degenerate (1), zero pad
    output logic [OUT_TDATA_W-1:0]                      o_m_tdata
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int AW = W + 2;
    localparam int BW = W + 1;
    localparam int HB = W / 2;
    localparam int HT = W - HB;
    localparam int SW = 2 * W + 5;
    localparam int IW = 2 * W + 4;
    localparam int RW = IW / 2 + Q_FRAC;
    localparam int NW = W + 28;
    localparam int ZW = NW + 1;
    localparam int DW = W + 3;
    localparam int SQ_SIDE_W = BW + AW + NW + 3;

    logic en;
    logic accept;

    // Stage 1: input registers
    logic                 r1_vld;
    logic signed [W-1:0]  r1_ym, r1_y0, r1_yp;

    // Stage 2: curvature and slope
    logic                 r2_vld;
    logic                 r2_aneg, r2_degen, r2_y0n;
    logic [AW-1:0]        r2_aa;
    logic signed [BW-1:0] r2_bs;
    logic [W-1:0]         r2_bm, r2_y0m;

    // Stage 3: partial products
    logic                 r3_vld;
    logic                 r3_aneg, r3_degen, r3_y0n;
    logic [AW-1:0]        r3_aa;
    logic signed [BW-1:0] r3_bs;
    logic [W+HB-1:0]      r3_bb_lo;
    logic [W+HT-1:0]      r3_bb_hi;
    logic [AW+HB-1:0]     r3_t_lo;
    logic [AW+HT-1:0]     r3_t_hi;

    // Stage 4: full products
    logic                 r4_vld;
    logic                 r4_aneg, r4_degen;
    logic [AW-1:0]        r4_aa;
    logic signed [BW-1:0] r4_bs;
    logic [2*W-1:0]       r4_bb;
    logic signed [SW-1:0] r4_t8;

    // Stage 5: discriminant and vertex numerator
    logic                 r5_vld;
    logic                 r5_degen, r5_rok, r5_ye_neg;
    logic [AW-1:0]        r5_aa;
    logic signed [BW-1:0] r5_bs;
    logic [IW-1:0]        r5_d;
    logic [NW-1:0]        r5_ye_mag;

    // Square root outputs
    logic                 sq_vld;
    logic [RW-1:0]        sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic signed [BW-1:0] sq_bs;
    logic [AW-1:0]        sq_aa;
    logic [NW-1:0]        sq_ye_mag;
    logic                 sq_ye_neg, sq_rok, sq_degen;

    // Stage 6: divider operands
    logic                 r6_vld;
    logic [NW-1:0]        r6_mag [4];
    logic [DW-1:0]        r6_den [4];
    logic                 r6_neg [4];
    logic                 r6_rok, r6_degen;

    logic                    dv_vld;
    logic signed [OUT_W-1:0] dv_quo [4];
    logic [1:0]              dv_side;

    t_result tail;
    t_result r_head, r_skid;
    logic    r_head_v, r_skid_v;
    logic    take;

    assign en         = !r_skid_v;
    assign o_s_tready = en;
    assign accept     = i_s_tvalid && en;

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ym <= $signed(i_s_tdata[W-1:0]);
            r1_y0 <= $signed(i_s_tdata[2*W-1:W]);
            r1_yp <= $signed(i_s_tdata[3*W-1:2*W]);
        end
    end

    // Stage 2: a2 = ym + yp - 2*y0 (twice the curvature), b2 = yp - ym.
    logic signed [AW-1:0] n2_a2, ym_e, y0_e, yp_e;
    logic signed [BW-1:0] n2_b2;

    always_comb begin
        ym_e  = AW'(r1_ym);
        y0_e  = AW'(r1_y0);
        yp_e  = AW'(r1_yp);
        n2_a2 = ym_e + yp_e - (y0_e <<< 1);
        n2_b2 = BW'(r1_yp) - BW'(r1_ym);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_aneg  <= n2_a2[AW-1];
            r2_degen <= (n2_a2 == '0);
            r2_aa    <= n2_a2[AW-1] ? AW'(-n2_a2) : AW'(n2_a2);
            r2_bs    <= n2_a2[AW-1] ? n2_b2 : -n2_b2;
            r2_bm    <= n2_b2[BW-1] ? W'(-n2_b2) : W'(n2_b2);
            r2_y0m   <= r1_y0[W-1] ? W'(-y0_e) : W'(y0_e);
            r2_y0n   <= r1_y0[W-1];
        end
    end

    // Stage 3: products split into two half-width partial products each.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_bb_lo <= (W+HB)'(r2_bm) * (W+HB)'(r2_bm[HB-1:0]);
            r3_bb_hi <= (W+HT)'(r2_bm) * (W+HT)'(r2_bm[W-1:HB]);
            r3_t_lo  <= (AW+HB)'(r2_aa) * (AW+HB)'(r2_y0m[HB-1:0]);
            r3_t_hi  <= (AW+HT)'(r2_aa) * (AW+HT)'(r2_y0m[W-1:HB]);
            r3_aneg  <= r2_aneg;
            r3_degen <= r2_degen;
            r3_y0n   <= r2_y0n;
            r3_aa    <= r2_aa;
            r3_bs    <= r2_bs;
        end
    end

    // Stage 4: b2^2 and 8*|a2|*y0.
    logic [2*W+1:0] n4_tm;
    logic [SW-1:0]  n4_t8u;

    always_comb begin
        n4_tm  = {r3_t_hi, {HB{1'b0}}} + (2*W+2)'(r3_t_lo);
        n4_t8u = {n4_tm, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_bb    <= {r3_bb_hi, {HB{1'b0}}} + (2*W)'(r3_bb_lo);
            r4_t8    <= r3_y0n ? $signed(-n4_t8u) : $signed(n4_t8u);
            r4_aneg  <= r3_aneg;
            r4_degen <= r3_degen;
            r4_aa    <= r3_aa;
            r4_bs    <= r3_bs;
        end
    end

    // Stage 5: d = b2^2 - 8*a2*y0; the vertex numerator takes the sign of a2 out.
    logic signed [SW-1:0] n5_bb, n5_d, n5_yn;
    logic [SW-1:0]        n5_ynm;
    logic [SW+Q_FRAC-1:0] n5_ye_big;

    always_comb begin
        n5_bb     = $signed(SW'(r4_bb));
        n5_d      = r4_aneg ? (n5_bb + r4_t8) : (n5_bb - r4_t8);
        n5_yn     = r4_aneg ? (r4_t8 + n5_bb) : (r4_t8 - n5_bb);
        n5_ynm    = n5_yn[SW-1] ? SW'(-n5_yn) : SW'(n5_yn);
        n5_ye_big = {n5_ynm, {Q_FRAC{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    // The vertex divisor carries a factor 2^(W+1), taken out here as a shift.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_d      <= n5_d[SW-1] ? '0 : IW'(n5_d);
            r5_rok    <= !r4_degen && !n5_d[SW-1];
            r5_ye_mag <= NW'(n5_ye_big >> (W + 1));
            r5_ye_neg <= n5_yn[SW-1];
            r5_degen  <= r4_degen;
            r5_aa     <= r4_aa;
            r5_bs     <= r4_bs;
        end
    end

    qtr_sqrt #(
        .IW     (IW),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_vld),
        .i_d     (r5_d),
        .i_side  ({r5_bs, r5_aa, r5_ye_mag, r5_ye_neg, r5_rok, r5_degen}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {sq_bs, sq_aa, sq_ye_mag, sq_ye_neg, sq_rok, sq_degen} = sq_side;

    // Stage 6: root numerators (bs << 24) -/+ s.
    logic signed [ZW-1:0] n6_base, n6_s, n6_zl, n6_zh;

    always_comb begin
        n6_base = ZW'(sq_bs) <<< Q_FRAC;
        n6_s    = $signed(ZW'(sq_root));
        n6_zl   = n6_base - n6_s;
        n6_zh   = n6_base + n6_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mag[0] <= n6_base[ZW-1] ? NW'(-n6_base) : NW'(n6_base);
            r6_neg[0] <= n6_base[ZW-1];
            r6_den[0] <= DW'({sq_aa, 1'b0});
            r6_mag[1] <= sq_ye_mag;
            r6_neg[1] <= sq_ye_neg;
            r6_den[1] <= DW'(sq_aa);
            r6_mag[2] <= n6_zl[ZW-1] ? NW'(-n6_zl) : NW'(n6_zl);
            r6_neg[2] <= n6_zl[ZW-1];
            r6_den[2] <= DW'({sq_aa, 1'b0});
            r6_mag[3] <= n6_zh[ZW-1] ? NW'(-n6_zh) : NW'(n6_zh);
            r6_neg[3] <= n6_zh[ZW-1];
            r6_den[3] <= DW'({sq_aa, 1'b0});
            r6_rok    <= sq_rok;
            r6_degen  <= sq_degen;
        end
    end

    qtr_div #(
        .NW     (NW),
        .DW     (DW),
        .LANES  (4),
        .SIDE_W (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_vld),
        .i_mag   (r6_mag),
        .i_den   (r6_den),
        .i_neg   (r6_neg),
        .i_side  ({r6_rok, r6_degen}),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Final assembly: root count, lower root replacement, masks for special cases.
    always_comb begin
        logic in_lo, in_hi, rok, degen;
        rok   = dv_side[1];
        degen = dv_side[0];
        in_lo = (dv_quo[2] >= NEG_ONE_Q) && (dv_quo[2] <= ONE_Q);
        in_hi = (dv_quo[3] >= NEG_ONE_Q) && (dv_quo[3] <= ONE_Q);
        tail  = '0;
        if (!degen) begin
            tail.extremum_x = dv_quo[0];
            tail.extremum_y = dv_quo[1];
        end
        tail.degenerate = degen;
        if (rok) begin
            tail.roots_real = 1'b1;
            tail.root_high  = dv_quo[3];
            tail.root_low   = (dv_quo[2] < NEG_ONE_Q) ? dv_quo[3] : dv_quo[2];
            tail.root_count = 2'(in_lo) + 2'(in_hi);
        end
    end

    // Two-entry output buffer; the pipeline freezes only while both entries are full.
    assign take = r_head_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (dv_vld) begin
            if (!r_head_v || take) begin
                r_head_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_head_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_head <= r_skid;
            end
        end else if (dv_vld) begin
            if (!r_head_v || take) begin
                r_head <= tail;
            end else begin
                r_skid <= tail;
            end
        end
    end

    assign o_m_tvalid = r_head_v;
    assign o_m_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, r_head};

    // The spare entry is only ever filled behind a waiting head.
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_head_v)
        else $error("output buffer spare entry holds data without a head entry");

    a_degenerate_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_v && r_head.degenerate) |->
            (!r_head.roots_real && r_head.root_count == 2'd0 && r_head.extremum_x == '0))
        else $error("flat input reported a vertex or roots");

    a_no_roots_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_v && !r_head.roots_real) |->
            (r_head.root_count == 2'd0 && r_head.root_low == '0 && r_head.root_high == '0))
        else $error("roots reported without a real solution");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_v |-> (r_head.root_count != 2'd3))
        else $error("root count beyond two");

endmodule

`default_nettype wire

// ===== hw/rtl/qtr_sqrt.sv =====
// Pipelined digit-by-digit square root, floor(2^24 * sqrt(d)), one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module qtr_sqrt
    import qtr_pkg::*;
#(
    parameter int IW     = 2 * SAMPLE_WIDTH_DEF + 4,
    parameter int SIDE_W = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [IW-1:0]         i_d,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_valid,
    output logic [IW/2+Q_FRAC-1:0]     o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int RW = IW / 2 + Q_FRAC;
    localparam int RB = RW + 2;

    logic [RW-1:0]     r_y    [1:RW];
    logic [RB-1:0]     r_r    [1:RW];
    logic [IW-1:0]     r_d    [1:RW];
    logic [SIDE_W-1:0] r_side [1:RW];
    logic              r_vld  [1:RW];

    for (genvar j = 0; j < RW; j++) begin : g_step
        logic [RW-1:0]     cy;
        logic [RB-1:0]     cr;
        logic [IW-1:0]     cd;
        logic [SIDE_W-1:0] cs;
        logic              cv;
        logic [1:0]        pair;
        logic [RB-1:0]     rr;
        logic [RB-1:0]     trial;
        logic              ge;

        if (j == 0) begin : g_first
            assign cy = '0;
            assign cr = '0;
            assign cd = i_d;
            assign cs = i_side;
            assign cv = i_valid;
        end else begin : g_next
            assign cy = r_y[j];
            assign cr = r_r[j];
            assign cd = r_d[j];
            assign cs = r_side[j];
            assign cv = r_vld[j];
        end

        // The scaled radicand has 48 zero bits below d, so late pairs are zero.
        if (2 * j < IW) begin : g_pair
            assign pair = cd[IW-1-2*j -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rr    = {cr[RB-3:0], pair};
        assign trial = {cy, 2'b01};
        assign ge    = (rr >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= cv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[j+1]    <= {cy[RW-2:0], ge};
                r_r[j+1]    <= ge ? (rr - trial) : rr;
                r_d[j+1]    <= cd;
                r_side[j+1] <= cs;
            end
        end
    end

    assign o_valid = r_vld[RW];
    assign o_root  = r_y[RW];
    assign o_side  = r_side[RW];

endmodule

`default_nettype wire

// ===== hw/rtl/qtr_div.sv =====
// Pipelined restoring divider lanes with truncation toward zero and 32-bit saturation.
`timescale 1ns / 1ps
`default_nettype none

module qtr_div
    import qtr_pkg::*;
#(
    parameter int NW     = SAMPLE_WIDTH_DEF + 28,
    parameter int DW     = SAMPLE_WIDTH_DEF + 3,
    parameter int LANES  = 4,
    parameter int SIDE_W = 2
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [NW-1:0]           i_mag  [LANES],
    input  wire logic [DW-1:0]           i_den  [LANES],
    input  wire logic                    i_neg  [LANES],
    input  wire logic [SIDE_W-1:0]       i_side,
    output logic                         o_valid,
    output logic signed [OUT_W-1:0]      o_quo  [LANES],
    output logic [SIDE_W-1:0]            o_side
);

    localparam int QW = OUT_W;
    localparam int CW = DW + QW;

    logic [NW-1:0]     r_rem  [0:QW][LANES];
    logic [DW-1:0]     r_den  [0:QW][LANES];
    logic [QW-1:0]     r_quo  [0:QW][LANES];
    logic              r_neg  [0:QW][LANES];
    logic              r_ovf  [0:QW][LANES];
    logic [SIDE_W-1:0] r_side [0:QW];
    logic              r_vld  [0:QW];

    // Entry stage: a quotient of 2^32 or more can only saturate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= i_mag[l];
                r_den[0][l] <= i_den[l];
                r_neg[0][l] <= i_neg[l];
                r_quo[0][l] <= '0;
                r_ovf[0][l] <= (CW'(i_mag[l]) >= {i_den[l], {QW{1'b0}}});
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int SH = QW - 1 - k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [CW-1:0] rz;
            logic [CW-1:0] dsh;
            logic          ge;

            assign rz  = CW'(r_rem[k][l]);
            assign dsh = CW'(r_den[k][l]) << SH;
            assign ge  = (rz >= dsh);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1][l] <= ge ? NW'(rz - dsh) : r_rem[k][l];
                    r_quo[k+1][l] <= {r_quo[k][l][QW-2:0], ge};
                    r_den[k+1][l] <= r_den[k][l];
                    r_neg[k+1][l] <= r_neg[k][l];
                    r_ovf[k+1][l] <= r_ovf[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_comb begin
        logic [QW-1:0] lim;
        logic [QW-1:0] mq;
        for (int l = 0; l < LANES; l++) begin
            lim = r_neg[QW][l] ? NEG_LIMIT : POS_LIMIT;
            mq  = (r_ovf[QW][l] || (r_quo[QW][l] > lim)) ? lim : r_quo[QW][l];
            o_quo[l] = r_neg[QW][l] ? $signed(-mq) : $signed(mq);
        end
    end

    assign o_valid = r_vld[QW];
    assign o_side  = r_side[QW];

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the three-point parabola extremum and root finder.
`timescale 1ns / 1ps

module testbench;
    import qtr_pkg::*;

    localparam int SW = 32;
    localparam int IN_W = ((3 * SW + 7) / 8) * 8;
    localparam int N_RANDOM = 880;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [127:0] wide_t;

    // Truncating division toward zero, clamped to the signed 32-bit range.
    function automatic logic signed [31:0] div_clamp(wide_t num, wide_t den);
        logic neg;
        wide_t mag;
        wide_t quo;
        wide_t lim;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / den;
        lim = neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF;
        if (quo > lim) quo = lim;
        if (neg) quo = -quo;
        return quo[31:0];
    endfunction

    function automatic wide_t isqrt(wide_t n);
        logic [127:0] rem;
        logic [127:0] res;
        logic [127:0] bitv;
        rem = n;
        res = 0;
        bitv = 128'd1 << 126;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_result fit_parabola(logic [IN_W-1:0] req);
        t_result r;
        wide_t ym, y0, yp, a2, b2, aa, bs, bb, t8, den2, disc, yn, s, base;
        wide_t one;
        r = '0;
        one = 128'sd1 <<< 24;
        ym = $signed(req[SW-1:0]);
        y0 = $signed(req[2*SW-1:SW]);
        yp = $signed(req[3*SW-1:2*SW]);
        a2 = ym + yp - 2 * y0;
        b2 = yp - ym;
        if (a2 == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        aa = (a2 > 0) ? a2 : -a2;
        bs = (a2 > 0) ? -b2 : b2;
        bb = b2 * b2;
        t8 = 8 * aa * y0;
        den2 = 2 * aa;
        disc = bb - 8 * a2 * y0;
        yn = (a2 > 0) ? t8 - bb : t8 + bb;
        r.extremum_x = div_clamp(bs <<< 24, den2);
        r.extremum_y = div_clamp(yn <<< 24, (8 * aa) <<< (SW - 2));
        if (disc >= 0) begin
            s = isqrt(disc <<< 48);
            base = bs <<< 24;
            r.roots_real = 1'b1;
            r.root_low = div_clamp(base - s, den2);
            r.root_high = div_clamp(base + s, den2);
            r.root_count = 0;
            if (wide_t'(r.root_low) >= -one && wide_t'(r.root_low) <= one)
                r.root_count = r.root_count + 1;
            if (wide_t'(r.root_high) >= -one && wide_t'(r.root_high) <= one)
                r.root_count = r.root_count + 1;
            if (wide_t'(r.root_low) < -one) r.root_low = r.root_high;
        end
        return r;
    endfunction

    class fit_scoreboard;
        t_result pending_q[$];
        int errors;
        int checked;

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function void note_request(logic [IN_W-1:0] req);
            pending_q.push_back(fit_parabola(req));
        endfunction

        task check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                report($sformatf("result with nothing pending: %h", got));
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.extremum_x !== want.extremum_x)
                report($sformatf("extremum_x %h, want %h", got.extremum_x, want.extremum_x));
            if (got.extremum_y !== want.extremum_y)
                report($sformatf("extremum_y %h, want %h", got.extremum_y, want.extremum_y));
            if (got.root_low !== want.root_low)
                report($sformatf("root_low %h, want %h", got.root_low, want.root_low));
            if (got.root_high !== want.root_high)
                report($sformatf("root_high %h, want %h", got.root_high, want.root_high));
            if (got.root_count !== want.root_count)
                report($sformatf("root_count %0d, want %0d", got.root_count, want.root_count));
            if (got.roots_real !== want.roots_real)
                report($sformatf("roots_real %b, want %b", got.roots_real, want.roots_real));
            if (got.degenerate !== want.degenerate)
                report($sformatf("degenerate %b, want %b", got.degenerate, want.degenerate));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata;
    logic o_m_tvalid;
    logic i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    fit_scoreboard sb;
    int phase;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_run;
    bit hold_done;
    int hold_left;
    int n_sent;
    int n_degen, n_real, n_complex;

    quadratic_three_point_roots_core #(.SAMPLE_WIDTH(SW)) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Receiver: random stalls per phase, plus a long hold-off each time phase one begins.
    always @(negedge i_clk) begin
        if (phase == 1 && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_result got;
            got = t_result'(o_m_tdata[RES_W-1:0]);
            if (got.degenerate) n_degen++;
            else if (got.roots_real) n_real++;
            else n_complex++;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    task send_request(logic [SW-1:0] ym, logic [SW-1:0] y0, logic [SW-1:0] yp);
        logic [IN_W-1:0] req;
        req = '0;
        req[3*SW-1:0] = {yp, y0, ym};
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = req;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(req);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Random magnitude: a full-width value shifted down by a random amount.
    function automatic logic [SW-1:0] rand_sample();
        logic signed [SW-1:0] v;
        v = $signed($urandom());
        return v >>> $urandom_range(31);
    endfunction

    // Sample of k*(x-r1)*(x-r2) at x, all in Q2.30, with |k| <= 0.25.
    function automatic logic [SW-1:0] eval_roots(longint k, longint r1, longint r2,
                                                 longint x);
        longint p;
        p = ((x - r1) * (x - r2)) >>> 30;
        return SW'((p * k) >>> 30);
    endfunction

    task send_random();
        int kind;
        longint k, r1, r2, one;
        logic [SW-1:0] y0, d;
        one = 64'sd1 << 30;
        kind = $urandom_range(9);
        if (kind < 5) begin
            r1 = $signed($urandom_range(32'h6000_0000)) - 64'sh3000_0000;
            r2 = $signed($urandom_range(32'h6000_0000)) - 64'sh3000_0000;
            k = $signed($urandom_range(32'h2000_0000)) - 64'sh1000_0000;
            send_request(eval_roots(k, r1, r2, -one), eval_roots(k, r1, r2, 0),
                         eval_roots(k, r1, r2, one));
        end else if (kind < 7) begin
            send_request(rand_sample(), rand_sample(), rand_sample());
        end else if (kind == 7) begin
            send_request($urandom(), $urandom(), $urandom());
        end else if (kind == 8) begin
            // Zero curvature: samples on a straight line.
            y0 = rand_sample() >>> 1;
            d = rand_sample() >>> 1;
            send_request(y0 - d, y0, y0 + d);
        end else begin
            y0 = rand_sample();
            send_request(y0 + $urandom_range(3), y0, y0 - $urandom_range(3));
        end
    endtask

    initial begin
        sb = new();
        phase = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_run = 0;
        hold_done = 1'b0;
        hold_left = 0;
        n_sent = 0;
        n_degen = 0;
        n_real = 0;
        n_complex = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: flat lines, sign extremes, both roots, none, and a far lower root.
        send_request(32'h0, 32'h0, 32'h0);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h3000_0000, 32'hF000_0000, 32'h3000_0000);
        send_request(32'h5000_0000, 32'h1000_0000, 32'h5000_0000);
        send_request(32'h0000_0000, 32'hE000_0000, 32'h0000_0000);
        send_request(32'hF400_0000, 32'hF400_0000, 32'h1400_0000);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_request(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_request(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'hC000_0000, 32'h4000_0000, 32'hC000_0000);
        send_request(32'h4000_0001, 32'h0000_0000, 32'h3FFF_FFFF);
        send_request(32'h8000_0001, 32'h8000_0000, 32'h8000_0001);

        for (int p = 0; p < 4; p++) begin
            phase = p;
            send_idle_pct = (p == 1 || p == 3) ? 62 : 0;
            recv_stall_pct = (p == 2) ? 62 : (p == 3) ? 7 : 0;
            if (p == 3) send_idle_pct = 7;
            if (p == 1) recv_stall_pct = 0;
            for (int i = 0; i < N_RANDOM / 4; i++) send_random();
        end
        // Keep offering without pause while the receiver is held, so the input stalls.
        phase = 1;
        hold_done = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 150; i++) send_random();
        i_s_tvalid = 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Sent %0d sample triples, checked %0d results across four idle patterns",
                 n_sent, sb.checked);
        $display("Results seen: %0d flat, %0d with real roots, %0d without",
                 n_degen, n_real, n_complex);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
